// ===== hdl/mog_background_subtractor_macros.svh =====
// Assertion macros for the Gaussian-mixture background subtractor.
// Used by the top level only; no other dependencies.
`ifndef MOG_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define MOG_BACKGROUND_SUBTRACTOR_MACROS_SVH
// same-cycle implication, disabled in reset
`define MOGBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled in reset
`define MOGBS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/mogbs_pkg.sv =====
// Shared types, widths and reset constants of the background subtractor.
// No dependencies.
package mogbs_pkg;
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned IDX_W   = 19;
   localparam int unsigned MEAN_W  = 16;
   localparam int unsigned VAR_W   = 24;
   localparam int unsigned WT_W    = 17;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 24;

   localparam int unsigned DEF_COMPONENTS = 3;
   localparam int unsigned DEF_PIXELS     = 524288;

   localparam logic [WT_W-1:0]  ONE_Q16 = 17'h10000;
   localparam logic [VAR_W-1:0] VAR_MAX = 24'hFFFFFF;

   localparam logic [15:0] RESET_LEARNING_RATE    = 16'd328;
   localparam logic [15:0] RESET_MATCH_FACTOR     = 16'd1600;
   localparam logic [16:0] RESET_WEIGHT_THRESHOLD = 17'd16384;
   localparam logic [23:0] RESET_INITIAL_VARIANCE = 24'd57600;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_FACTOR     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_THRESHOLD = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE = 4'd3;

   typedef struct packed {
      logic [WT_W-1:0]   weight;
      logic [VAR_W-1:0]  variance;
      logic [MEAN_W-1:0] mean;
   } comp_type;

   localparam int unsigned COMP_W = $bits(comp_type);

   typedef struct packed {
      logic [23:0] initial_variance;
      logic [16:0] weight_threshold;
      logic [15:0] match_factor;
      logic [15:0] learning_rate;
   } cfg_type;

   typedef struct packed {
      logic             foreground_flag;
      logic [PIX_W-1:0] background_value;
   } result_type;
endpackage

// ===== hdl/mog_background_subtractor.sv =====
// Gaussian-mixture background subtractor, one gray pixel per request word, one
// response word (background byte and foreground flag) per request. Each pixel's
// mixture lives in one row of an on-chip memory and is read, updated by a shared
// sequencer and written back. The sequencer tests each component for a match,
// updates every matched component, normalizes the weights with a bit-serial
// divider and forms the output sums; the row read and the hand-off come before
// and after, and the divider dominates. After reset a clearing pass writes the
// reset mixture to every row, one row per cycle, during which no request is
// taken; configuration writes are taken at any time.
// Depends on mogbs_pkg, mogbs_row_ram, mogbs_core and the macros header.
`include "mog_background_subtractor_macros.svh"
module mog_background_subtractor #(
   parameter int unsigned COMPONENTS = mogbs_pkg::DEF_COMPONENTS,
   parameter int unsigned PIXELS     = mogbs_pkg::DEF_PIXELS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // pixel_value, pixel_index
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,  // background_value, foreground_flag
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mogbs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mogbs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mogbs_pkg::*;

   localparam int unsigned ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned ROW_W  = COMPONENTS * COMP_W + 1;
   localparam int unsigned SPAN   = (COMPONENTS > 1) ? (COMPONENTS - 1) : 1;
   localparam logic [WT_W-1:0] WT_INIT = WT_W'(65536 / COMPONENTS);
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(PIXELS - 1);

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_START, ST_BUSY, ST_DONE} state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [PIX_W-1:0]  pixel_ff;
   logic              oor_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   cfg_type           cfg_ff;

   comp_type [COMPONENTS-1:0] rst_comps;
   comp_type [COMPONENTS-1:0] core_comps;
   logic [ROW_W-1:0]  rd_row;
   logic [ROW_W-1:0]  wr_row;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic              core_start;
   logic              core_done;
   logic              core_fg;
   result_type        core_result;
   logic              out_free;
   logic              req_fire;
   logic              oor_in;

   for (genvar g = 0; g < COMPONENTS; g++) begin : g_rst
      localparam int unsigned MeanInit = (65280 * g) / SPAN;
      assign rst_comps[g] = '{weight: WT_INIT, variance: RESET_INITIAL_VARIANCE,
                              mean: MEAN_W'(MeanInit)};
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign oor_in     = ({13'b0, req_tdata[26:8]} >= 32'(PIXELS));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign core_start = (state_ff == ST_START);
   assign csr_ready  = 1'b1;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_row  = {1'b0, rst_comps};
      end else begin
         wr_en   = (state_ff == ST_DONE) && out_free && !oor_ff;
         wr_addr = addr_ff;
         wr_row  = {core_fg, core_comps};
      end
   end

   mogbs_row_ram #(
      .DATA_W (ROW_W),
      .DEPTH  (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (addr_ff),
      .rd_data (rd_row)
   );

   mogbs_core #(
      .COMPONENTS (COMPONENTS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .pixel     (pixel_ff),
      .cfg       (cfg_ff),
      .comps_in  (rd_row[ROW_W-2:0]),
      .fg_in     (rd_row[ROW_W-1]),
      .done      (core_done),
      .comps_out (core_comps),
      .fg_out    (core_fg),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learning_rate    <= RESET_LEARNING_RATE;
         cfg_ff.match_factor     <= RESET_MATCH_FACTOR;
         cfg_ff.weight_threshold <= RESET_WEIGHT_THRESHOLD;
         cfg_ff.initial_variance <= RESET_INITIAL_VARIANCE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:    cfg_ff.learning_rate    <= csr_data[15:0];
            CSR_MATCH_FACTOR:     cfg_ff.match_factor     <= csr_data[15:0];
            CSR_WEIGHT_THRESHOLD: cfg_ff.weight_threshold <= csr_data[16:0];
            CSR_INITIAL_VARIANCE: cfg_ff.initial_variance <= csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         oor_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_ROW) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  pixel_ff <= req_tdata[7:0];
                  addr_ff  <= ADDR_W'(req_tdata[26:8]);
                  oor_ff   <= oor_in;
                  state_ff <= oor_in ? ST_DONE : ST_READ;
               end
            end
            ST_READ:  state_ff <= ST_START;
            ST_START: state_ff <= ST_BUSY;
            ST_BUSY: begin
               if (core_done) begin
                  state_ff <= ST_DONE;
               end
            end
            default: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= oor_ff ? '0 : core_result;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.foreground_flag, rsp_ff.background_value};

   `MOGBS_ASSERT_IMP(a_done_when_busy, clock, reset, core_done, state_ff == ST_BUSY, "core done outside busy")
   `MOGBS_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE, "idle after accept")
   `MOGBS_ASSERT_NXT(a_clear_advances, clock, reset, (state_ff == ST_CLEAR) && (clr_cnt_ff != LAST_ROW), clr_cnt_ff == $past(clr_cnt_ff) + 1'b1, "clear pass skipped a row")
endmodule

// ===== hdl/mogbs_row_ram.sv =====
// Single-port-write, single-port-read synchronous row memory with registered read data.
// No dependencies.
module mogbs_row_ram #(
   parameter int unsigned DATA_W = 172,
   parameter int unsigned DEPTH  = 524288,
   parameter int unsigned ADDR_W = 19
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/mogbs_core.sv =====
// Per-pixel mixture update sequencer: match, adapt, replace, normalize, output.
// Depends on mogbs_pkg.
module mogbs_core #(
   parameter int unsigned COMPONENTS = mogbs_pkg::DEF_COMPONENTS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [mogbs_pkg::PIX_W-1:0]             pixel,
   input  mogbs_pkg::cfg_type                      cfg,
   input  mogbs_pkg::comp_type [COMPONENTS-1:0]    comps_in,
   input  logic                                    fg_in,
   output logic                                    done,
   output mogbs_pkg::comp_type [COMPONENTS-1:0]    comps_out,
   output logic                                    fg_out,
   output mogbs_pkg::result_type                   result
);
   import mogbs_pkg::*;

   localparam int unsigned KW    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
   localparam int unsigned SUM_W = WT_W + $clog2(COMPONENTS);
   localparam int unsigned ACC_W = 33 + KW + 1;
   localparam logic [WT_W-1:0] WT_INIT = WT_W'(65536 / COMPONENTS);

   typedef enum logic [2:0] {ST_IDLE, ST_UPD, ST_REPL, ST_NORM, ST_OUT, ST_FIN} state_type;

   state_type state_ff;
   logic [KW-1:0]     k_ff;
   logic [3:0]        step_ff;
   logic [PIX_W-1:0]  pixel_ff;
   logic [MEAN_W-1:0] mean_ff [COMPONENTS];
   logic [VAR_W-1:0]  var_ff [COMPONENTS];
   logic [WT_W-1:0]   wt_ff [COMPONENTS];
   logic [31:0]       d2_ff [COMPONENTS];
   logic [39:0]       mv_ff;
   logic [33:0]       t_ff;
   logic [WT_W-1:0]   w1_ff;
   logic [15:0]       b_ff;
   logic [32:0]       p1_ff;
   logic [31:0]       p2_ff;
   logic [31:0]       d2n_ff;
   logic [40:0]       vt_ff;
   logic [47:0]       q_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [WT_W-1:0]   minw_ff;
   logic [KW-1:0]     best_ff;
   logic              matched_ff;
   logic [32:0]       num_ff;
   logic [32:0]       quo_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [5:0]        div_cnt_ff;
   logic [32:0]       mw_ff;
   logic [39:0]       fm_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              flag_ff;
   logic              scan_done_ff;
   logic              done_ff;
   logic [PIX_W-1:0]  bg_ff;

   logic [MEAN_W-1:0] pix_q;
   logic [MEAN_W-1:0] cur_m;
   logic [VAR_W-1:0]  cur_v;
   logic [WT_W-1:0]   cur_w;
   logic              last_k;
   logic [WT_W-1:0]   one_minus_a;
   logic [WT_W-1:0]   one_minus_b;
   logic [MEAN_W-1:0] dist_in;
   logic [31:0]       d2_in;
   logic [39:0]       mv_in;
   logic [33:0]       t_in;
   logic [34:0]       wsum_in;
   logic [WT_W-1:0]   w1_in;
   logic [32:0]       bprod_in;
   logic [32:0]       p1_in;
   logic [31:0]       p2_in;
   logic [33:0]       msum_in;
   logic [40:0]       vt_in;
   logic [47:0]       q_in;
   logic [49:0]       nvsum_in;
   logic [VAR_W-1:0]  nv_in;
   logic [SUM_W:0]    rem_try_in;
   logic              rem_ge_in;
   logic [SUM_W:0]    rem_sub_in;
   logic [ACC_W-25:0] bg_sh_in;

   always_comb begin
      pix_q       = {pixel_ff, 8'b0};
      cur_m       = mean_ff[k_ff];
      cur_v       = var_ff[k_ff];
      cur_w       = wt_ff[k_ff];
      last_k      = (k_ff == KW'(COMPONENTS - 1));
      one_minus_a = ONE_Q16 - {1'b0, cfg.learning_rate};
      one_minus_b = ONE_Q16 - {1'b0, b_ff};
      dist_in     = (pix_q >= cur_m) ? (pix_q - cur_m) : (cur_m - pix_q);
      d2_in       = {16'b0, dist_in} * {16'b0, dist_in};
      mv_in       = {24'b0, cfg.match_factor} * {16'b0, cur_v};
      t_in        = {17'b0, cur_w} * {17'b0, one_minus_a};
      wsum_in     = {1'b0, t_ff} + {3'b0, cfg.learning_rate, 16'b0};
      w1_in       = (wsum_in[34:16] > {2'b0, ONE_Q16}) ? ONE_Q16 : wsum_in[32:16];
      bprod_in    = {17'b0, cfg.learning_rate} * {16'b0, w1_ff};
      p1_in       = {16'b0, one_minus_b} * {17'b0, cur_m};
      p2_in       = {16'b0, b_ff} * {16'b0, pix_q};
      msum_in     = {1'b0, p1_ff} + {2'b0, p2_ff};
      vt_in       = {17'b0, cur_v} * {24'b0, one_minus_b};
      q_in        = {16'b0, d2n_ff} * {32'b0, b_ff};
      nvsum_in    = {1'b0, vt_ff, 8'b0} + {2'b0, q_ff};
      nv_in       = (nvsum_in[49:24] > {2'b0, VAR_MAX}) ? VAR_MAX : nvsum_in[47:24];
      rem_try_in  = {rem_ff, num_ff[32]};
      rem_ge_in   = (rem_try_in >= {1'b0, sum_ff});
      rem_sub_in  = rem_try_in - {1'b0, sum_ff};
      bg_sh_in    = acc_ff[ACC_W-1:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  for (int i = 0; i < COMPONENTS; i++) begin
                     mean_ff[i] <= comps_in[i].mean;
                     var_ff[i]  <= comps_in[i].variance;
                     wt_ff[i]   <= comps_in[i].weight;
                  end
                  pixel_ff     <= pixel;
                  flag_ff      <= fg_in;
                  sum_ff       <= '0;
                  matched_ff   <= 1'b0;
                  acc_ff       <= '0;
                  scan_done_ff <= 1'b0;
                  k_ff         <= '0;
                  step_ff      <= '0;
                  state_ff     <= ST_UPD;
               end
            end
            ST_UPD: begin
               unique case (step_ff)
                  4'd0: begin
                     d2_ff[k_ff] <= d2_in;
                     mv_ff       <= mv_in;
                     if ((k_ff == '0) || (cur_w < minw_ff)) begin
                        minw_ff <= cur_w;
                        best_ff <= k_ff;
                     end
                     step_ff <= 4'd1;
                  end
                  4'd1: begin
                     if ({8'b0, d2_ff[k_ff]} <= mv_ff) begin
                        matched_ff <= 1'b1;
                        t_ff       <= t_in;
                        step_ff    <= 4'd2;
                     end else begin
                        sum_ff  <= sum_ff + SUM_W'(cur_w);
                        step_ff <= 4'd0;
                        if (last_k) begin
                           k_ff     <= '0;
                           state_ff <= matched_ff ? ST_NORM : ST_REPL;
                        end else begin
                           k_ff <= k_ff + 1'b1;
                        end
                     end
                  end
                  4'd2: begin
                     w1_ff   <= w1_in;
                     step_ff <= 4'd3;
                  end
                  4'd3: begin
                     b_ff        <= bprod_in[31:16];
                     wt_ff[k_ff] <= w1_ff;
                     step_ff     <= 4'd4;
                  end
                  4'd4: begin
                     p1_ff   <= p1_in;
                     p2_ff   <= p2_in;
                     step_ff <= 4'd5;
                  end
                  4'd5: begin
                     mean_ff[k_ff] <= msum_in[31:16];
                     step_ff       <= 4'd6;
                  end
                  4'd6: begin
                     d2n_ff  <= d2_in;
                     vt_ff   <= vt_in;
                     step_ff <= 4'd7;
                  end
                  4'd7: begin
                     q_ff    <= q_in;
                     step_ff <= 4'd8;
                  end
                  default: begin
                     var_ff[k_ff] <= nv_in;
                     sum_ff       <= sum_ff + SUM_W'(cur_w);
                     step_ff      <= 4'd0;
                     if (last_k) begin
                        k_ff     <= '0;
                        state_ff <= ST_NORM;
                     end else begin
                        k_ff <= k_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_REPL: begin
               wt_ff[best_ff]   <= WT_INIT;
               mean_ff[best_ff] <= pix_q;
               var_ff[best_ff]  <= cfg.initial_variance;
               sum_ff           <= sum_ff - SUM_W'(minw_ff) + SUM_W'(WT_INIT);
               k_ff             <= '0;
               step_ff          <= '0;
               state_ff         <= ST_NORM;
            end
            ST_NORM: begin
               unique case (step_ff)
                  4'd0: begin
                     if (sum_ff == '0) begin
                        k_ff     <= '0;
                        state_ff <= ST_OUT;
                     end else begin
                        num_ff     <= {cur_w, 16'b0};
                        rem_ff     <= '0;
                        quo_ff     <= '0;
                        div_cnt_ff <= '0;
                        step_ff    <= 4'd1;
                     end
                  end
                  4'd1: begin
                     num_ff     <= {num_ff[31:0], 1'b0};
                     quo_ff     <= {quo_ff[31:0], rem_ge_in};
                     rem_ff     <= rem_ge_in ? rem_sub_in[SUM_W-1:0] : rem_try_in[SUM_W-1:0];
                     div_cnt_ff <= div_cnt_ff + 1'b1;
                     if (div_cnt_ff == 6'd32) begin
                        step_ff <= 4'd2;
                     end
                  end
                  default: begin
                     wt_ff[k_ff] <= quo_ff[WT_W-1:0];
                     step_ff     <= 4'd0;
                     if (last_k) begin
                        k_ff     <= '0;
                        state_ff <= ST_OUT;
                     end else begin
                        k_ff <= k_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_OUT: begin
               if (step_ff == 4'd0) begin
                  mw_ff   <= {17'b0, cur_m} * {16'b0, cur_w};
                  fm_ff   <= {24'b0, cfg.match_factor} * {16'b0, cur_v};
                  step_ff <= 4'd1;
               end else begin
                  acc_ff <= acc_ff + ACC_W'(mw_ff);
                  if (!scan_done_ff && (cur_w > cfg.weight_threshold)) begin
                     if ({8'b0, d2_ff[k_ff]} <= fm_ff) begin
                        flag_ff      <= 1'b0;
                        scan_done_ff <= 1'b1;
                     end else begin
                        flag_ff <= 1'b1;
                     end
                  end
                  step_ff <= 4'd0;
                  if (last_k) begin
                     state_ff <= ST_FIN;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: begin
               bg_ff    <= (bg_sh_in > (ACC_W-24)'(255)) ? 8'hFF : bg_sh_in[7:0];
               done_ff  <= 1'b1;
               k_ff     <= '0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < COMPONENTS; i++) begin
         comps_out[i].mean     = mean_ff[i];
         comps_out[i].variance = var_ff[i];
         comps_out[i].weight   = wt_ff[i];
      end
   end

   assign done                    = done_ff;
   assign fg_out                  = flag_ff;
   assign result.background_value = bg_ff;
   assign result.foreground_flag  = flag_ff;
endmodule

// ===== tb/sv/mog_background_subtractor_tb.sv =====
// Self-checking testbench for mog_background_subtractor: streams pixels,
// predicts every response word from its own mixture model and compares.
// Depends on mogbs_pkg and the mog_background_subtractor top level.
module mog_background_subtractor_tb;
   import mogbs_pkg::*;

   localparam int unsigned NCOMP     = DEF_COMPONENTS;
   localparam int unsigned NPIX      = DEF_PIXELS;
   localparam int unsigned IDLE_MAX  = 2000000;
   localparam int unsigned TAIL_WAIT = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 4'd5;

   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic [PIX_W-1:0] pixel_value;
   } pixel_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   mog_background_subtractor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // model copy of the registers and the per-pixel mixtures
   logic [15:0] alpha_q16 = RESET_LEARNING_RATE;
   logic [15:0] match_q8  = RESET_MATCH_FACTOR;
   logic [16:0] thresh_q16 = RESET_WEIGHT_THRESHOLD;
   logic [23:0] fresh_var = RESET_INITIAL_VARIANCE;

   logic [MEAN_W-1:0] mean_mem[int unsigned];
   logic [VAR_W-1:0]  var_mem[int unsigned];
   logic [WT_W-1:0]   wt_mem[int unsigned];
   bit                fg_mem[int unsigned];

   pixel_word_t pending_pixels[$];
   result_type  expected_rsp[$];

   int unsigned n_sent = 0, n_rcvd = 0, n_csr = 0, n_errors = 0, n_fg = 0;
   int unsigned idle_cycles = 0;

   function automatic longint unsigned dist_sq(longint unsigned a, longint unsigned b);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   function automatic bit in_range(longint unsigned d2, longint unsigned v);
      return d2 <= longint'(match_q8) * v;
   endfunction

   function automatic result_type model_pixel(pixel_word_t pw);
      result_type      r;
      longint unsigned pv, a, m, v, w, b, nv, total, bg;
      longint unsigned d2[NCOMP];
      longint unsigned cm[NCOMP], cv[NCOMP], cw[NCOMP];
      int unsigned     base, best, hits;
      bit              flag;
      pv = longint'(pw.pixel_value) << 8;
      a = alpha_q16;
      total = 0;
      hits = 0;
      base = pw.pixel_index * NCOMP;
      for (int k = 0; k < NCOMP; k++) begin
         cm[k] = mean_mem.exists(base + k) ? mean_mem[base + k]
                                           : (longint'(255 * 256) * k) / (NCOMP > 1 ? NCOMP - 1 : 1);
         cv[k] = var_mem.exists(base + k) ? var_mem[base + k] : RESET_INITIAL_VARIANCE;
         cw[k] = wt_mem.exists(base + k) ? wt_mem[base + k] : 65536 / NCOMP;
      end
      for (int k = 0; k < NCOMP; k++) begin
         m = cm[k]; v = cv[k]; w = cw[k];
         d2[k] = dist_sq(pv, m);
         if (in_range(d2[k], v)) begin
            hits++;
            w = (w * (65536 - a) + a * 65536) >> 16;
            if (w > 65536) w = 65536;
            b = (a * w) >> 16;
            m = (((65536 - b) * m) + b * pv) >> 16;
            nv = (((v * (65536 - b)) << 8) + dist_sq(pv, m) * b) >> 24;
            if (nv > 64'hFFFFFF) nv = 64'hFFFFFF;
            cm[k] = m; cv[k] = nv; cw[k] = w;
         end
         total += cw[k];
      end
      if (hits == 0) begin
         best = 0;
         for (int k = 1; k < NCOMP; k++)
            if (cw[k] < cw[best]) best = k;
         total -= cw[best];
         cw[best] = 65536 / NCOMP;
         total += cw[best];
         cm[best] = pv;
         cv[best] = fresh_var;
      end
      if (total != 0)
         for (int k = 0; k < NCOMP; k++) cw[k] = (cw[k] << 16) / total;
      bg = 0;
      for (int k = 0; k < NCOMP; k++) bg += cm[k] * cw[k];
      bg >>= 24;
      if (bg > 255) bg = 255;
      flag = fg_mem.exists(pw.pixel_index) ? fg_mem[pw.pixel_index] : 1'b0;
      for (int k = 0; k < NCOMP; k++) begin
         if (cw[k] > thresh_q16) begin
            if (in_range(d2[k], cv[k])) begin
               flag = 1'b0;
               break;
            end
            flag = 1'b1;
         end
      end
      for (int k = 0; k < NCOMP; k++) begin
         mean_mem[base + k] = cm[k][MEAN_W-1:0];
         var_mem[base + k]  = cv[k][VAR_W-1:0];
         wt_mem[base + k]   = cw[k][WT_W-1:0];
      end
      fg_mem[pw.pixel_index] = flag;
      r.background_value = bg[7:0];
      r.foreground_flag  = flag;
      return r;
   endfunction

   // driver: bursts with random gaps, valid held until the word is taken
   int unsigned burst_left = 4, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(model_pixel(pending_pixels.pop_front()));
            n_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, pending_pixels[0]};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 300);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall pattern on ready changes periodically at random
   int unsigned stall_mode = 0, cyc = 0;
   always @(posedge clock) begin
      cyc++;
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= (cyc % 3 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rcvd++;
         if (expected_rsp.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected response word %h", rsp_tdata);
         end else begin
            result_type e;
            e = expected_rsp.pop_front();
            if (rsp_tdata[7:0] !== e.background_value || rsp_tdata[8] !== e.foreground_flag
                || rsp_tdata[15:9] !== 7'b0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch word %0d: expected bg %0d fg %0b, got bg %0d fg %0b",
                           n_rcvd, e.background_value, e.foreground_flag,
                           rsp_tdata[7:0], rsp_tdata[8]);
            end
            if (e.foreground_flag) n_fg++;
         end
      end
   end

   // watchdog: the clearing pass after reset is the longest quiet stretch
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEARNING_RATE:    alpha_q16 = val[15:0];
         CSR_MATCH_FACTOR:     match_q8 = val[15:0];
         CSR_WEIGHT_THRESHOLD: thresh_q16 = val[16:0];
         CSR_INITIAL_VARIANCE: fresh_var = val[23:0];
         default: ;
      endcase
      n_csr++;
   endtask

   task automatic write_all(logic [15:0] lr, logic [15:0] mf, logic [16:0] th,
                            logic [23:0] iv);
      write_reg(CSR_LEARNING_RATE, {8'($urandom_range(0, 255)), lr});
      write_reg(CSR_MATCH_FACTOR, {8'($urandom_range(0, 255)), mf});
      write_reg(CSR_WEIGHT_THRESHOLD, {7'($urandom_range(0, 127)), th});
      write_reg(CSR_INITIAL_VARIANCE, iv);
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_pixels.size() > 0 || expected_rsp.size() > 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic queue_pixel(int unsigned v, int unsigned idx);
      pixel_word_t pw;
      pw.pixel_value = v[7:0];
      pw.pixel_index = idx[IDX_W-1:0];
      pending_pixels.push_back(pw);
   endtask

   // mostly stable pixels with noise, some changes and some full-range words
   task automatic queue_random(int unsigned count);
      int unsigned pool[8], level[8];
      int unsigned s, v;
      for (int i = 0; i < 8; i++) begin
         pool[i] = (i < 2) ? i : $urandom_range(0, NPIX - 1);
         level[i] = $urandom_range(0, 255);
      end
      for (int unsigned n = 0; n < count; n++) begin
         s = $urandom_range(0, 7);
         case ($urandom_range(0, 9))
            0: queue_pixel($urandom_range(0, 255), $urandom_range(0, NPIX - 1));
            1: begin
               level[s] = $urandom_range(0, 255);
               queue_pixel(level[s], pool[s]);
            end
            2: queue_pixel($urandom_range(0, 255), pool[s]);
            default: begin
               v = level[s] + $urandom_range(0, 12);
               v = (v < 6) ? 0 : v - 6;
               queue_pixel(v > 255 ? 255 : v, pool[s]);
            end
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, ties at reset, repeats that match, alternation that replaces
      queue_pixel(0, 0);
      queue_pixel(255, NPIX - 1);
      queue_pixel(128, 12345);
      for (int i = 0; i < 6; i++) queue_pixel(0, 0);
      for (int i = 0; i < 4; i++) queue_pixel((i % 2) ? 255 : 60, 7);
      for (int i = 0; i < 5; i++) queue_pixel(200, NPIX - 1);
      queue_pixel(10, NPIX - 1);
      queue_pixel(127, 'h2AAAA);
      queue_pixel(85, 'h55555);
      drain();
      queue_random(400);
      drain();
      write_all(16'hFFFF, 16'hFFFF, 17'd0, 24'hFFFFFF);
      queue_pixel(255, 0);
      queue_pixel(0, 0);
      queue_random(240);
      drain();
      write_all(16'd0, 16'd0, 17'h10000, 24'd0);
      write_reg(CSR_UNUSED, 24'($urandom_range(0, 24'hFFFFFF)));
      queue_pixel(0, 3);
      queue_pixel(0, 3);
      queue_random(240);
      drain();
      write_all(16'd3000, 16'd2304, 17'd20000, 24'd8000);
      queue_random(400);
      drain();
      write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                17'($urandom_range(0, 65536)), 24'($urandom_range(0, 24'hFFFFFF)));
      queue_random(340);
      drain();
      $display("sent %0d pixels, got %0d responses (%0d foreground), %0d register writes",
               n_sent, n_rcvd, n_fg, n_csr);
      $display("settings: reset values, both extremes, moderate and random; %0d mismatches",
               n_errors);
      if (n_errors == 0 && expected_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== mog_background_subtractor.f =====
+incdir+hdl
hdl/mogbs_pkg.sv
hdl/mogbs_row_ram.sv
hdl/mogbs_core.sv
hdl/mog_background_subtractor.sv
tb/sv/mog_background_subtractor_tb.sv
